@@ hdl/tsct_pkg.sv @@
package tsct_pkg;

	// command codes
	localparam logic [1:0] CMD_REGISTER = 2'd0;
	localparam logic [1:0] CMD_ARRIVAL  = 2'd1;
	localparam logic [1:0] CMD_COMPLETE = 2'd2;

	// origin codes
	localparam logic [2:0] ORG_DIRECT_A = 3'd0;
	localparam logic [2:0] ORG_DIRECT_B = 3'd1;
	localparam logic [2:0] ORG_POOL_A   = 3'd2;
	localparam logic [2:0] ORG_POOL_B   = 3'd3;
	localparam logic [2:0] ORG_POOL_C   = 3'd4;

	// task kinds
	localparam logic [1:0] KIND_ALONE = 2'd0;
	localparam logic [1:0] KIND_WHOLE = 2'd1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SLOT  = 2'd1;
	localparam logic [1:0] ST_BAD_KIND = 2'd2;
	localparam logic [1:0] ST_SLOT_ERR = 2'd3;

	localparam logic [14:0] CNT_MAX = 15'h7fff;

	// one table entry
	typedef struct packed {
		logic        busy;
		logic [14:0] worker_target;
		logic [14:0] worker_done;
		logic [14:0] tasker_target;
		logic [14:0] tasker_done;
	} entry_t;

	// result word held until the sink takes it
	typedef struct packed {
		logic [1:0]         status;
		logic [9:0]         slot_id;
		logic signed [15:0] count;
		logic               is_last;
	} result_t;

	function automatic logic [14:0] sat_inc(input logic [14:0] v);
		return (v == CNT_MAX) ? v : v + 15'd1;
	endfunction

endpackage

@@ hdl/tsct_ifs.sv @@
interface tsct_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [2:0]  origin;
	logic [1:0]  task_kind;
	logic [14:0] worker_count;
	logic [14:0] tasker_count;
	logic [9:0]  slot;

	modport source (
		output valid, command, origin, task_kind, worker_count, tasker_count, slot,
		input  ready
	);
	modport sink (
		input  valid, command, origin, task_kind, worker_count, tasker_count, slot,
		output ready
	);
endinterface

interface tsct_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [9:0]         slot_id;
	logic signed [15:0] count;
	logic               is_last;

	modport source (
		output valid, status, slot_id, count, is_last,
		input  ready
	);
	modport sink (
		input  valid, status, slot_id, count, is_last,
		output ready
	);
endinterface

@@ hdl/tsct_ram.sv @@
module tsct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/task_slot_completion_tracker.sv @@
// a register-direct, arrival or completion word is read from the table on accept,
//   updated and written back in S_RMW, then held in S_RESP until the output is free;
//   a pooled register first scans upward from DIRECT_SLOTS in S_SCAN to a free slot
//   (no free slot gives ST_NO_SLOT), and a bad slot, origin or command goes to S_RESP
// one word in flight at a time (req.ready only in S_IDLE); reset is asynchronous,
//   after which a clearing pass zeroes the table while req.ready stays low
module task_slot_completion_tracker #(
	parameter int TOTAL_SLOTS  = 1024,
	parameter int DIRECT_SLOTS = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	tsct_req_if.sink   req,
	tsct_rsp_if.source rsp
);

	localparam int AW = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int EW = $bits(tsct_pkg::entry_t);
	localparam bit POOL_EMPTY = (DIRECT_SLOTS >= TOTAL_SLOTS);
	localparam logic [AW-1:0] POOL_BASE = POOL_EMPTY ? '0 : AW'(DIRECT_SLOTS);
	localparam logic [AW-1:0] LAST_SLOT = AW'(TOTAL_SLOTS - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_RMW   = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [AW-1:0] addr_q, addr_d;

	logic [1:0]  cmd_q;
	logic [1:0]  kind_q;
	logic [14:0] wcnt_q;
	logic [14:0] tcnt_q;
	logic [9:0]  slot_q;

	tsct_pkg::result_t res_q, res_d;
	tsct_pkg::result_t out_q;
	logic              out_valid_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	tsct_pkg::entry_t  ram_wdata, ram_rdata, upd_entry;
	logic [EW-1:0]     ram_rdata_raw;
	logic              upd_we;
	tsct_pkg::result_t upd_res;

	logic          accept;
	logic          req_slot_ok;
	logic [AW-1:0] req_addr;
	logic          rsp_free;

	assign accept      = req.valid && req.ready;
	assign req_slot_ok = (17'(req.slot) < 17'(TOTAL_SLOTS));
	assign req_addr    = AW'(17'(req.slot));
	assign rsp_free    = !out_valid_q || rsp.ready;
	assign req.ready   = (state_q == S_IDLE);

	assign ram_rdata = tsct_pkg::entry_t'(ram_rdata_raw);

	tsct_ram #(
		.WIDTH(EW),
		.DEPTH(TOTAL_SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);

	// entry update for the word held in the field registers
	always_comb begin
		upd_entry       = ram_rdata;
		upd_we          = 1'b0;
		upd_res.status  = tsct_pkg::ST_OK;
		upd_res.slot_id = slot_q;
		upd_res.count   = '0;
		upd_res.is_last = 1'b0;
		case (cmd_q)
			tsct_pkg::CMD_REGISTER: begin
				if (ram_rdata.busy) begin
					upd_res.status = tsct_pkg::ST_SLOT_ERR;
				end else begin
					upd_we                    = 1'b1;
					upd_entry.worker_done     = '0;
					upd_entry.tasker_done     = '0;
					case (kind_q)
						tsct_pkg::KIND_ALONE: begin
							upd_entry.busy          = 1'b1;
							upd_entry.worker_target = 15'd1;
							upd_entry.tasker_target = 15'd1;
							upd_res.slot_id         = 10'(17'(addr_q));
						end
						tsct_pkg::KIND_WHOLE: begin
							upd_entry.busy          = 1'b1;
							upd_entry.worker_target = wcnt_q;
							upd_entry.tasker_target = tcnt_q;
							upd_res.slot_id         = 10'(17'(addr_q));
						end
						default: begin
							upd_entry.busy = 1'b0;
							upd_res.status = tsct_pkg::ST_BAD_KIND;
						end
					endcase
				end
			end
			tsct_pkg::CMD_ARRIVAL: begin
				upd_we                = 1'b1;
				upd_entry.tasker_done = tsct_pkg::sat_inc(ram_rdata.tasker_done);
				upd_res.count         = 16'(upd_entry.tasker_done);
				upd_res.is_last       = (upd_entry.tasker_done == ram_rdata.tasker_target);
			end
			tsct_pkg::CMD_COMPLETE: begin
				if (!ram_rdata.busy) begin
					upd_res.status = tsct_pkg::ST_SLOT_ERR;
				end else if (ram_rdata.worker_target != '0 &&
				             ram_rdata.worker_done == ram_rdata.worker_target - 15'd1) begin
					// last worker frees the slot
					upd_we          = 1'b1;
					upd_entry       = '0;
					upd_res.is_last = 1'b1;
				end else begin
					upd_we                = 1'b1;
					upd_entry.worker_done = tsct_pkg::sat_inc(ram_rdata.worker_done);
					upd_res.count         = {1'b0, ram_rdata.worker_target}
					                      - {1'b0, ram_rdata.worker_done};
				end
			end
			default: begin
				upd_res.status = tsct_pkg::ST_NO_SLOT;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		addr_d    = addr_q;
		res_d     = res_q;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = req_addr;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				addr_d = addr_q + 1'b1;
				if (addr_q == LAST_SLOT) begin
					addr_d  = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				res_d.status  = tsct_pkg::ST_NO_SLOT;
				res_d.slot_id = req.slot;
				res_d.count   = '0;
				res_d.is_last = 1'b0;
				if (accept) begin
					state_d = S_RESP;
					case (req.command) inside
						tsct_pkg::CMD_REGISTER: begin
							case (req.origin) inside
								tsct_pkg::ORG_DIRECT_A, tsct_pkg::ORG_DIRECT_B: begin
									if (req_slot_ok) begin
										ram_re  = 1'b1;
										addr_d  = req_addr;
										state_d = S_RMW;
									end
								end
								tsct_pkg::ORG_POOL_A, tsct_pkg::ORG_POOL_B,
								tsct_pkg::ORG_POOL_C: begin
									if (!POOL_EMPTY) begin
										ram_re    = 1'b1;
										ram_raddr = POOL_BASE;
										addr_d    = POOL_BASE;
										state_d   = S_SCAN;
									end
								end
								default: begin
									state_d = S_RESP;
								end
							endcase
						end
						tsct_pkg::CMD_ARRIVAL, tsct_pkg::CMD_COMPLETE: begin
							if (req_slot_ok) begin
								ram_re  = 1'b1;
								addr_d  = req_addr;
								state_d = S_RMW;
							end
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SCAN: begin
				// one slot per cycle, upward from the pool base
				ram_raddr = addr_q + 1'b1;
				if (!ram_rdata.busy) begin
					state_d = S_RMW;
				end else if (addr_q == LAST_SLOT) begin
					res_d.status  = tsct_pkg::ST_NO_SLOT;
					res_d.slot_id = slot_q;
					res_d.count   = '0;
					res_d.is_last = 1'b0;
					state_d       = S_RESP;
				end else begin
					ram_re = 1'b1;
					addr_d = addr_q + 1'b1;
				end
			end
			S_RMW: begin
				ram_we    = upd_we;
				ram_wdata = upd_entry;
				res_d     = upd_res;
				state_d   = S_RESP;
			end
			S_RESP: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			if (state_q == S_RESP && rsp_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// word fields and result payload
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			cmd_q  <= req.command;
			kind_q <= req.task_kind;
			wcnt_q <= req.worker_count;
			tcnt_q <= req.tasker_count;
			slot_q <= req.slot;
		end
		if (state_q == S_RESP && rsp_free) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_q.status;
	assign rsp.slot_id = out_q.slot_id;
	assign rsp.count   = out_q.count;
	assign rsp.is_last = out_q.is_last;

endmodule

@@ hdl/tsct_chk.sv @@
module tsct_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [1:0]         rsp_status,
	input logic [9:0]         rsp_slot_id,
	input logic signed [15:0] rsp_count,
	input logic               rsp_is_last
);

	// a stalled result word stays up
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	// a stalled result word keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_slot_id)
		&& $stable(rsp_count) && $stable(rsp_is_last))
		else $error("result payload changed while stalled");

	// one word at a time: ready drops right after a word is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second word taken while one is in flight");

	// error results carry no count and no last flag
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != tsct_pkg::ST_OK |-> rsp_count == '0 && !rsp_is_last)
		else $error("error result with count or last flag");

endmodule

bind task_slot_completion_tracker tsct_chk u_tsct_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_slot_id(rsp.slot_id),
	.rsp_count  (rsp.count),
	.rsp_is_last(rsp.is_last)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	localparam int SLOT_TOTAL  = 1024;
	localparam int SLOT_DIRECT = 512;

	// codes the package leaves unnamed
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam logic [2:0] ORG_BAD_LO  = 3'd5;
	localparam logic [2:0] ORG_BAD_HI  = 3'd7;
	localparam logic [1:0] KIND_BAD_LO = 2'd2;
	localparam logic [1:0] KIND_BAD_HI = 2'd3;

	// one request word as it sits on the bus
	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  origin;
		logic [1:0]  task_kind;
		logic [14:0] worker_count;
		logic [14:0] tasker_count;
		logic [9:0]  slot;
	} req_word_t;

	logic clk = 1'b0;
	logic arst_n;

	tsct_req_if req_bus ();
	tsct_rsp_if rsp_bus ();

	task_slot_completion_tracker #(
		.TOTAL_SLOTS  (SLOT_TOTAL),
		.DIRECT_SLOTS (SLOT_DIRECT)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always #5 clk = ~clk;

	// shadow of the slot table
	bit        busy_mark [SLOT_TOTAL];
	bit [14:0] wk_target [SLOT_TOTAL];
	bit [14:0] wk_done   [SLOT_TOTAL];
	bit [14:0] tk_target [SLOT_TOTAL];
	bit [14:0] tk_done   [SLOT_TOTAL];

	req_word_t         word_queue [$];
	tsct_pkg::result_t due_results [$];
	req_word_t         next_word;
	req_word_t         taken_word;
	tsct_pkg::result_t want;

	int  words_queued = 0;
	int  words_taken  = 0;
	int  bad_count    = 0;
	int  idle_pct     = 0;
	int  stall_pct    = 0;
	int  send_gap     = 0;
	int  hold_gap     = 0;
	logic req_fire    = 1'b0;

	function automatic logic [14:0] step_up(input logic [14:0] v);
		return (v == tsct_pkg::CNT_MAX) ? v : v + 15'd1;
	endfunction

	// apply one accepted word to the shadow table and return its result
	function automatic tsct_pkg::result_t apply_word(input req_word_t w);
		tsct_pkg::result_t r;
		int      id;
		int      i;
		int      lim;
		int      done;
		int      diff;
		logic    hit;
		r.status  = tsct_pkg::ST_OK;
		r.slot_id = w.slot;
		r.count   = '0;
		r.is_last = 1'b0;
		hit = 1'b0;
		id  = 0;
		// slot is 10 bits wide, so it never reaches past the table here
		case (w.command)
			tsct_pkg::CMD_REGISTER: begin
				if (w.origin == tsct_pkg::ORG_DIRECT_A || w.origin == tsct_pkg::ORG_DIRECT_B) begin
					if (busy_mark[w.slot])
						r.status = tsct_pkg::ST_SLOT_ERR;
					else begin
						id  = w.slot;
						hit = 1'b1;
					end
				end else if (w.origin == tsct_pkg::ORG_POOL_A ||
						w.origin == tsct_pkg::ORG_POOL_B ||
						w.origin == tsct_pkg::ORG_POOL_C) begin
					for (i = SLOT_DIRECT; i < SLOT_TOTAL && !hit; i++)
						if (!busy_mark[i]) begin
							id  = i;
							hit = 1'b1;
						end
					if (!hit)
						r.status = tsct_pkg::ST_NO_SLOT;
				end else
					r.status = tsct_pkg::ST_NO_SLOT;
				if (hit) begin
					wk_done[id] = '0;
					tk_done[id] = '0;
					if (w.task_kind == tsct_pkg::KIND_ALONE) begin
						wk_target[id] = 15'd1;
						tk_target[id] = 15'd1;
						busy_mark[id] = 1'b1;
						r.slot_id = id[9:0];
					end else if (w.task_kind == tsct_pkg::KIND_WHOLE) begin
						wk_target[id] = w.worker_count;
						tk_target[id] = w.tasker_count;
						busy_mark[id] = 1'b1;
						r.slot_id = id[9:0];
					end else begin
						// bad kind gives the slot back, targets stay
						busy_mark[id] = 1'b0;
						r.status = tsct_pkg::ST_BAD_KIND;
					end
				end
			end
			tsct_pkg::CMD_ARRIVAL: begin
				tk_done[w.slot] = step_up(tk_done[w.slot]);
				r.count   = {1'b0, tk_done[w.slot]};
				r.is_last = (tk_done[w.slot] == tk_target[w.slot]);
			end
			tsct_pkg::CMD_COMPLETE: begin
				if (!busy_mark[w.slot])
					r.status = tsct_pkg::ST_SLOT_ERR;
				else begin
					lim  = wk_target[w.slot];
					done = wk_done[w.slot];
					if (lim > 0 && done == lim - 1) begin
						// last worker clears and frees the slot
						wk_target[w.slot] = '0;
						wk_done[w.slot]   = '0;
						tk_target[w.slot] = '0;
						tk_done[w.slot]   = '0;
						busy_mark[w.slot] = 1'b0;
						r.is_last = 1'b1;
					end else begin
						wk_done[w.slot] = step_up(wk_done[w.slot]);
						diff    = lim - done;
						r.count = diff[15:0];
					end
				end
			end
			default: r.status = tsct_pkg::ST_NO_SLOT;
		endcase
		return r;
	endfunction

	task automatic note_fail(input string what, input int exp_v, input int got_v);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
		bad_count++;
	endtask

	// driver: words and result back-pressure change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			// offer the next word once the current one is gone
			if (!req_bus.valid || req_fire) begin
				if (send_gap > 0) begin
					send_gap--;
					req_bus.valid <= 1'b0;
				end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
					send_gap = $urandom_range(0, 6);
					req_bus.valid <= 1'b0;
				end else if (word_queue.size() != 0) begin
					next_word = word_queue.pop_front();
					{req_bus.command, req_bus.origin, req_bus.task_kind,
						req_bus.worker_count, req_bus.tasker_count,
						req_bus.slot} <= next_word;
					req_bus.valid <= 1'b1;
				end else
					req_bus.valid <= 1'b0;
			end
			// result side stalls
			if (hold_gap > 0) begin
				hold_gap--;
				rsp_bus.ready <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				hold_gap = $urandom_range(0, 6);
				rsp_bus.ready <= 1'b0;
			end else
				rsp_bus.ready <= 1'b1;
		end
	end

	// monitor: predict on each accepted word, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			req_fire <= req_bus.valid && req_bus.ready;
			if (req_bus.valid && req_bus.ready) begin
				taken_word = {req_bus.command, req_bus.origin, req_bus.task_kind,
					req_bus.worker_count, req_bus.tasker_count, req_bus.slot};
				due_results.push_back(apply_word(taken_word));
				words_taken <= words_taken + 1;
			end
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with nothing pending, expected none, got slot_id %0d",
						$time, rsp_bus.slot_id);
					bad_count++;
				end else begin
					want = due_results.pop_front();
					if (rsp_bus.status !== want.status)
						note_fail("status", want.status, rsp_bus.status);
					if (rsp_bus.slot_id !== want.slot_id)
						note_fail("slot_id", want.slot_id, rsp_bus.slot_id);
					if (rsp_bus.count !== want.count)
						note_fail("count", $signed(want.count), $signed(rsp_bus.count));
					if (rsp_bus.is_last !== want.is_last)
						note_fail("is_last", want.is_last, rsp_bus.is_last);
				end
			end
		end
	end

	task automatic queue_word(input req_word_t w);
		word_queue.push_back(w);
		words_queued++;
	endtask

	task automatic put_word(input logic [1:0] cmd, input logic [2:0] org,
			input logic [1:0] kind, input logic [14:0] wc, input logic [14:0] tc,
			input logic [9:0] slot);
		queue_word({cmd, org, kind, wc, tc, slot});
	endtask

	function automatic req_word_t noise_word();
		req_word_t w;
		w.command      = 2'($urandom_range(0, 3));
		w.origin       = 3'($urandom_range(0, 7));
		w.task_kind    = 2'($urandom_range(0, 3));
		w.worker_count = 15'($urandom_range(0, 32767));
		w.tasker_count = 15'($urandom_range(0, 32767));
		w.slot         = 10'($urandom_range(0, SLOT_TOTAL - 1));
		return w;
	endfunction

	function automatic logic [2:0] pool_origin();
		case ($urandom_range(0, 2))
			0: return tsct_pkg::ORG_POOL_A;
			1: return tsct_pkg::ORG_POOL_B;
			default: return tsct_pkg::ORG_POOL_C;
		endcase
	endfunction

	function automatic logic [2:0] direct_origin();
		return $urandom_range(0, 1) ? tsct_pkg::ORG_DIRECT_B : tsct_pkg::ORG_DIRECT_A;
	endfunction

	// wait until the table shadow has seen every queued word and, with drain set, every result
	task automatic settle(input bit drain);
		while (words_taken != words_queued)
			@(negedge clk);
		if (drain)
			while (due_results.size() != 0)
				@(negedge clk);
	endtask

	// a few tasks through their life: registrations first, then a shuffled
	// mix of arrivals and completions
	task automatic run_tasks(input int n);
		req_word_t w;
		req_word_t ops [$];
		bit        claim [SLOT_TOTAL];
		int        s, j, k, tries, wc, tc, na, nc;
		for (int t = 0; t < n; t++) begin
			w = noise_word();
			w.command = tsct_pkg::CMD_REGISTER;
			s = -1;
			k = $urandom_range(0, 99);
			if ($urandom_range(0, 1)) begin
				w.origin = direct_origin();
				for (tries = 0; tries < 16 && s < 0; tries++) begin
					j = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SLOT_TOTAL - 1)
						: $urandom_range(0, SLOT_DIRECT - 1);
					if (!busy_mark[j] && !claim[j])
						s = j;
				end
				if (s < 0)
					continue;
				w.slot = s[9:0];
			end else begin
				w.origin = pool_origin();
				for (j = SLOT_DIRECT; j < SLOT_TOTAL && s < 0; j++)
					if (!busy_mark[j] && !claim[j])
						s = j;
			end
			wc = 0;
			tc = 0;
			if (k < 25) begin
				w.task_kind = tsct_pkg::KIND_ALONE;
				wc = 1;
				tc = 1;
			end else if (k < 92) begin
				w.task_kind = tsct_pkg::KIND_WHOLE;
				wc = $urandom_range(1, 4);
				tc = $urandom_range(0, 4);
				w.worker_count = wc[14:0];
				w.tasker_count = tc[14:0];
			end else if (k < 96) begin
				// large targets: touched a little, left in use
				w.task_kind = tsct_pkg::KIND_WHOLE;
				wc = 2;
				tc = 2;
			end else begin
				w.task_kind = $urandom_range(0, 1) ? KIND_BAD_HI : KIND_BAD_LO;
				s = -1;
			end
			queue_word(w);
			if (s < 0)
				continue;
			claim[s] = 1'b1;
			na = tc + (($urandom_range(0, 3) == 0) ? 1 : 0);
			nc = wc;
			if ($urandom_range(0, 9) == 0)
				nc = nc - 1;
			else if ($urandom_range(0, 9) == 0)
				nc = nc + 1;
			repeat (na) begin
				w = noise_word();
				w.command = tsct_pkg::CMD_ARRIVAL;
				w.slot = s[9:0];
				ops.push_back(w);
			end
			repeat (nc) begin
				w = noise_word();
				w.command = tsct_pkg::CMD_COMPLETE;
				w.slot = s[9:0];
				ops.push_back(w);
			end
		end
		for (j = ops.size() - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			w = ops[j];
			ops[j] = ops[k];
			ops[k] = w;
		end
		foreach (ops[i])
			queue_word(ops[i]);
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 6))
			queue_word(noise_word());
	endtask

	task automatic random_until(input int total);
		while (words_queued < total) begin
			if ($urandom_range(0, 3) == 0)
				run_noise();
			else
				run_tasks($urandom_range(1, 3));
			settle($urandom_range(0, 15) == 0);
		end
	endtask

	function automatic int pick_idle();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 25;
			default: return 50;
		endcase
	endfunction

	// give up on a hung run
	initial begin
		#(80_000_000);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		req_word_t w;
		int        s, need, freed, n;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		{req_bus.command, req_bus.origin, req_bus.task_kind, req_bus.worker_count,
			req_bus.tasker_count, req_bus.slot} = '0;
		rsp_bus.ready = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: life of a slot, error paths and field extremes
		idle_pct  = 20;
		stall_pct = 20;
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd0);
		put_word(tsct_pkg::CMD_ARRIVAL, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd0);
		put_word(tsct_pkg::CMD_COMPLETE, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd0);
		put_word(tsct_pkg::CMD_COMPLETE, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd0);
		put_word(tsct_pkg::CMD_ARRIVAL, tsct_pkg::ORG_POOL_A, tsct_pkg::KIND_WHOLE,
			'0, '0, 10'd5);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_DIRECT_B, tsct_pkg::KIND_WHOLE,
			tsct_pkg::CNT_MAX, tsct_pkg::CNT_MAX, 10'd511);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd511);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_POOL_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd0);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_POOL_B, tsct_pkg::KIND_WHOLE,
			15'd2, '0, 10'd1023);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_POOL_C, KIND_BAD_HI,
			tsct_pkg::CNT_MAX, tsct_pkg::CNT_MAX, 10'd700);
		put_word(tsct_pkg::CMD_REGISTER, ORG_BAD_LO, tsct_pkg::KIND_ALONE, '0, '0, 10'd3);
		put_word(tsct_pkg::CMD_REGISTER, ORG_BAD_HI, tsct_pkg::KIND_WHOLE,
			15'd1, 15'd1, 10'd4);
		put_word(CMD_UNUSED, ORG_BAD_HI, KIND_BAD_HI, tsct_pkg::CNT_MAX, tsct_pkg::CNT_MAX,
			10'd1023);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_DIRECT_B, KIND_BAD_LO,
			15'd5, 15'd5, 10'd1023);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_WHOLE,
			'0, '0, 10'd1023);
		put_word(tsct_pkg::CMD_COMPLETE, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd1023);
		put_word(tsct_pkg::CMD_COMPLETE, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd1023);
		put_word(tsct_pkg::CMD_COMPLETE, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd513);
		put_word(tsct_pkg::CMD_COMPLETE, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd513);
		put_word(tsct_pkg::CMD_ARRIVAL, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd513);
		put_word(tsct_pkg::CMD_ARRIVAL, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd511);
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_POOL_A, tsct_pkg::KIND_WHOLE,
			15'd3, 15'd2, 10'd0);
		put_word(tsct_pkg::CMD_ARRIVAL, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd513);
		put_word(tsct_pkg::CMD_ARRIVAL, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd513);
		settle(1'b1);

		// random task traffic
		while (words_queued < 560) begin
			idle_pct  = pick_idle();
			stall_pct = pick_idle();
			random_until(words_queued + 40);
		end
		settle(1'b1);

		// fill every pooled slot, mixing direct and pooled claims in order
		for (s = SLOT_DIRECT; s < SLOT_TOTAL; s++)
			if (!busy_mark[s]) begin
				w = noise_word();
				w.command = tsct_pkg::CMD_REGISTER;
				w.task_kind = tsct_pkg::KIND_ALONE;
				if ($urandom_range(0, 1)) begin
					w.origin = direct_origin();
					w.slot = s[9:0];
				end else
					w.origin = pool_origin();
				queue_word(w);
			end
		settle(1'b0);

		// pool exhausted
		repeat (6) begin
			w = noise_word();
			w.command = tsct_pkg::CMD_REGISTER;
			w.origin = pool_origin();
			queue_word(w);
		end
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_DIRECT_B, tsct_pkg::KIND_ALONE,
			'0, '0, 10'd600);
		settle(1'b1);

		// free part of the pool again
		freed = 0;
		for (s = SLOT_DIRECT; s < SLOT_TOTAL && freed < 160; s++) begin
			need = wk_target[s];
			need = need - wk_done[s];
			if (busy_mark[s] && wk_target[s] != '0 && need >= 1 && need <= 4 &&
					$urandom_range(0, 3) == 0) begin
				repeat (need) begin
					w = noise_word();
					w.command = tsct_pkg::CMD_COMPLETE;
					w.slot = s[9:0];
					queue_word(w);
				end
				freed++;
			end
		end
		settle(1'b0);

		while (words_queued < 1230) begin
			idle_pct  = pick_idle();
			stall_pct = pick_idle();
			random_until(words_queued + 30);
		end

		// closing stretch at full rate
		idle_pct  = 0;
		stall_pct = 0;
		random_until(1350);
		settle(1'b0);

		// zero worker target: completions run past the target and go negative
		s = 0;
		while (busy_mark[s] && s < SLOT_DIRECT - 1)
			s++;
		put_word(tsct_pkg::CMD_REGISTER, tsct_pkg::ORG_DIRECT_A, tsct_pkg::KIND_WHOLE,
			'0, tsct_pkg::CNT_MAX, s[9:0]);
		repeat (4) begin
			w = noise_word();
			w.command = tsct_pkg::CMD_ARRIVAL;
			w.slot = s[9:0];
			queue_word(w);
		end
		repeat (4) begin
			w = noise_word();
			w.command = tsct_pkg::CMD_COMPLETE;
			w.slot = s[9:0];
			queue_word(w);
		end
		settle(1'b0);

		// let the last results come out
		for (n = 0; n < 200000 && due_results.size() != 0; n++)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (due_results.size() != 0) begin
			$display("%0t: results outstanding, expected 0, got %0d", $time,
				due_results.size());
			bad_count++;
		end
		if (bad_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/tsct_pkg.sv
hdl/tsct_ifs.sv
hdl/tsct_ram.sv
hdl/task_slot_completion_tracker.sv
hdl/tsct_chk.sv
tb/testbench.sv
